// ===== rtl/core/lmpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpm_pkg
// Shared types and constants of the LED matrix pixel mapper.
// ----------------------------------------------------------------------------
package lmpm_pkg;

    localparam int unsigned SIDE_W   = 9;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [SIDE_W-1:0] MAX_SIDE     = 9'd256;
    localparam logic [SIDE_W-1:0] RESET_WIDTH  = 9'd16;
    localparam logic [SIDE_W-1:0] RESET_HEIGHT = 9'd16;

    localparam logic [7:0] CHANNEL_MAX = 8'd255;

    // Command codes on the request channel
    localparam logic [1:0] FUNC_PIXEL_565   = 2'd0;
    localparam logic [1:0] FUNC_PIXEL_BYTES = 2'd1;
    localparam logic [1:0] FUNC_BATCH_BEGIN = 2'd2;
    localparam logic [1:0] FUNC_BATCH_END   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZIGZAG        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT        = 3'd6;

    typedef struct packed {
        logic [SIDE_W-1:0] matrix_width;
        logic [SIDE_W-1:0] matrix_height;
        logic              flip_x;
        logic              flip_y;
        logic              swap_axes;
        logic              zigzag_wiring;
        logic              invert_colour;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        packed_colour;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } req_t;

    typedef struct packed {
        logic        write_pixel;
        logic [15:0] led_index;
        logic [7:0]  green_out;
        logic [7:0]  red_out;
        logic [7:0]  blue_out;
        logic        refresh_now;
    } rsp_t;

    // Batch counter status seen by the mapping logic
    typedef struct packed {
        logic depth_zero;
        logic depth_le_one;
    } batch_stat_t;

endpackage

// ===== rtl/core/lmpm_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpm_req_if
// Request channel: pixel writes and batch commands.
// ----------------------------------------------------------------------------
interface lmpm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        packed_colour;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;

    modport source
    (
        output valid, func, pos_x, pos_y, packed_colour, red_in, green_in, blue_in,
        input  ready
    );

    modport sink
    (
        input  valid, func, pos_x, pos_y, packed_colour, red_in, green_in, blue_in,
        output ready
    );
endinterface

// ===== rtl/core/lmpm_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpm_rsp_if
// Result channel: LED writes and refresh requests.
// ----------------------------------------------------------------------------
interface lmpm_rsp_if;
    logic        valid;
    logic        ready;
    logic        write_pixel;
    logic [15:0] led_index;
    logic [7:0]  green_out;
    logic [7:0]  red_out;
    logic [7:0]  blue_out;
    logic        refresh_now;

    modport source
    (
        output valid, write_pixel, led_index, green_out, red_out, blue_out, refresh_now,
        input  ready
    );

    modport sink
    (
        input  valid, write_pixel, led_index, green_out, red_out, blue_out, refresh_now,
        output ready
    );
endinterface

// ===== rtl/core/led_matrix_pixel_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_pixel_mapper
// Maps pixel writes onto an LED strip wired as a matrix.
//
// Requests enter on req: pixel writes (565 or byte colour) and batch begin/end
// commands. Results leave on rsp: LED writes, or refresh-only beats for batch
// ends that leave no batch open. Off-matrix writes and batch begins make no
// beat. Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the
// user must write it only while idle, and the block does not enforce this.
//
// One request is taken every cycle while rsp does not stall. A request is held
// in the input register and its result then in the output register. The batch
// nesting counter updates as each request leaves the input register, so its
// effect is seen by the next one. When rsp stalls the output register holds
// its beat, the input register fills, and req.ready drops; requests with no
// result still drain. Reset empties both registers, clears the batch counter
// and loads a 16 x 16 linear matrix with no flips and no colour inversion.
// ----------------------------------------------------------------------------
module led_matrix_pixel_mapper
#(
    parameter int unsigned MAX_NESTING = 255
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lmpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lmpm_pkg::SIDE_W-1:0]         cfg_wdata,
    lmpm_req_if.sink                            req,
    lmpm_rsp_if.source                          rsp
);

    localparam int unsigned DEPTH_W = $clog2(MAX_NESTING + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NESTING);

    lmpm_pkg::cfg_t        cfg;
    lmpm_pkg::req_t        req_beat;
    lmpm_pkg::req_t        s1_req_reg;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    lmpm_pkg::rsp_t        out_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DEPTH_W-1:0]    depth_reg;
    logic [DEPTH_W-1:0]    depth_next;
    lmpm_pkg::batch_stat_t stat;
    logic                  has_result;
    lmpm_pkg::rsp_t        map_rsp;
    logic                  out_free;
    logic                  s1_retire;
    logic                  in_take;

    lmpm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign stat.depth_zero   = (depth_reg == '0);
    assign stat.depth_le_one = (depth_reg <= DEPTH_W'(1));

    lmpm_map u_map
    (
        .cfg        (cfg),
        .req        (s1_req_reg),
        .stat       (stat),
        .has_result (has_result),
        .rsp        (map_rsp)
    );

    assign req_beat.func          = req.func;
    assign req_beat.pos_x         = req.pos_x;
    assign req_beat.pos_y         = req.pos_y;
    assign req_beat.packed_colour = req.packed_colour;
    assign req_beat.red_in        = req.red_in;
    assign req_beat.green_in      = req.green_in;
    assign req_beat.blue_in       = req.blue_in;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_retire = s1_valid_reg && (!has_result || out_free);
    assign req.ready = !s1_valid_reg || s1_retire;
    assign in_take   = req.valid && req.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_retire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_retire && has_result)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;

        depth_next = depth_reg;
        if (s1_retire)
        begin
            case (s1_req_reg.func)
                lmpm_pkg::FUNC_BATCH_BEGIN:
                begin
                    if (depth_reg < DEPTH_MAX)
                        depth_next = depth_reg + DEPTH_W'(1);
                end
                lmpm_pkg::FUNC_BATCH_END:
                begin
                    if (depth_reg != '0)
                        depth_next = depth_reg - DEPTH_W'(1);
                end
                default:
                begin
                    depth_next = depth_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            depth_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_req_reg <= req_beat;
        if (s1_retire && has_result)
            out_reg <= map_rsp;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.write_pixel = out_reg.write_pixel;
    assign rsp.led_index   = out_reg.led_index;
    assign rsp.green_out   = out_reg.green_out;
    assign rsp.red_out     = out_reg.red_out;
    assign rsp.blue_out    = out_reg.blue_out;
    assign rsp.refresh_now = out_reg.refresh_now;

endmodule

// ===== rtl/core/lmpm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpm_cfg
// Configuration register file; matrix sides saturate at the maximum side.
// ----------------------------------------------------------------------------
module lmpm_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lmpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lmpm_pkg::SIDE_W-1:0]         cfg_wdata,
    output lmpm_pkg::cfg_t                      cfg
);

    lmpm_pkg::cfg_t              cfg_reg;
    lmpm_pkg::cfg_t              cfg_next;
    logic [lmpm_pkg::SIDE_W-1:0] side_sat;

    assign side_sat = (cfg_wdata > lmpm_pkg::MAX_SIDE) ? lmpm_pkg::MAX_SIDE : cfg_wdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                lmpm_pkg::REG_MATRIX_WIDTH:  cfg_next.matrix_width  = side_sat;
                lmpm_pkg::REG_MATRIX_HEIGHT: cfg_next.matrix_height = side_sat;
                lmpm_pkg::REG_FLIP_X:        cfg_next.flip_x        = cfg_wdata[0];
                lmpm_pkg::REG_FLIP_Y:        cfg_next.flip_y        = cfg_wdata[0];
                lmpm_pkg::REG_SWAP_AXES:     cfg_next.swap_axes     = cfg_wdata[0];
                lmpm_pkg::REG_ZIGZAG:        cfg_next.zigzag_wiring = cfg_wdata[0];
                lmpm_pkg::REG_INVERT:        cfg_next.invert_colour = cfg_wdata[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.matrix_width  <= lmpm_pkg::RESET_WIDTH;
            cfg_reg.matrix_height <= lmpm_pkg::RESET_HEIGHT;
            cfg_reg.flip_x        <= 1'b0;
            cfg_reg.flip_y        <= 1'b0;
            cfg_reg.swap_axes     <= 1'b0;
            cfg_reg.zigzag_wiring <= 1'b0;
            cfg_reg.invert_colour <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/lmpm_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpm_map
// Coordinate transform, bounds check, strip index and colour path.
// ----------------------------------------------------------------------------
module lmpm_map
(
    input  lmpm_pkg::cfg_t        cfg,
    input  lmpm_pkg::req_t        req,
    input  lmpm_pkg::batch_stat_t stat,
    output logic                  has_result,
    output lmpm_pkg::rsp_t        rsp
);

    logic signed [17:0] pos_x_ext;
    logic signed [17:0] pos_y_ext;
    logic signed [17:0] width_s;
    logic signed [17:0] height_s;
    logic signed [17:0] rot_w;
    logic signed [17:0] rot_h;
    logic signed [17:0] flip_xv;
    logic signed [17:0] flip_yv;
    logic signed [17:0] map_x;
    logic signed [17:0] map_y;
    logic               in_bounds;
    logic [8:0]         col_x;
    logic [8:0]         row_y;
    logic [8:0]         col;
    logic [17:0]        row_base;
    logic [18:0]        index_sum;
    logic               is_565;
    logic [7:0]         red_raw;
    logic [7:0]         green_raw;
    logic [7:0]         blue_raw;
    logic               is_pixel;

    assign pos_x_ext = 18'(req.pos_x);
    assign pos_y_ext = 18'(req.pos_y);
    assign width_s   = $signed({9'd0, cfg.matrix_width});
    assign height_s  = $signed({9'd0, cfg.matrix_height});
    assign rot_w     = cfg.swap_axes ? height_s : width_s;
    assign rot_h     = cfg.swap_axes ? width_s : height_s;

    assign flip_xv = cfg.flip_x ? (rot_w - pos_x_ext - 18'sd1) : pos_x_ext;
    assign flip_yv = cfg.flip_y ? (rot_h - pos_y_ext - 18'sd1) : pos_y_ext;
    assign map_x   = cfg.swap_axes ? flip_yv : flip_xv;
    assign map_y   = cfg.swap_axes ? flip_xv : flip_yv;

    assign in_bounds = !map_x[17] && !map_y[17] && (map_x < width_s) && (map_y < height_s);

    assign col_x     = map_x[8:0];
    assign row_y     = map_y[8:0];
    assign col       = (cfg.zigzag_wiring && row_y[0])
                       ? (cfg.matrix_width - col_x - 9'd1) : col_x;
    assign row_base  = row_y * cfg.matrix_width;
    assign index_sum = {1'b0, row_base} + {10'd0, col};

    assign is_565    = (req.func == lmpm_pkg::FUNC_PIXEL_565);
    assign red_raw   = is_565 ? {3'd0, req.packed_colour[15:11]} : req.red_in;
    assign green_raw = is_565 ? {2'd0, req.packed_colour[10:5]}  : req.green_in;
    assign blue_raw  = is_565 ? {3'd0, req.packed_colour[4:0]}   : req.blue_in;

    assign is_pixel = (req.func == lmpm_pkg::FUNC_PIXEL_565)
                   || (req.func == lmpm_pkg::FUNC_PIXEL_BYTES);

    always_comb
    begin
        rsp        = '0;
        has_result = 1'b0;
        case (req.func)
            lmpm_pkg::FUNC_PIXEL_565,
            lmpm_pkg::FUNC_PIXEL_BYTES:
            begin
                has_result      = is_pixel && in_bounds;
                rsp.write_pixel = 1'b1;
                rsp.led_index   = index_sum[15:0];
                rsp.red_out     = cfg.invert_colour ? (lmpm_pkg::CHANNEL_MAX - red_raw)
                                                    : red_raw;
                rsp.green_out   = cfg.invert_colour ? (lmpm_pkg::CHANNEL_MAX - green_raw)
                                                    : green_raw;
                rsp.blue_out    = cfg.invert_colour ? (lmpm_pkg::CHANNEL_MAX - blue_raw)
                                                    : blue_raw;
                rsp.refresh_now = stat.depth_zero;
            end
            lmpm_pkg::FUNC_BATCH_END:
            begin
                has_result      = stat.depth_le_one;
                rsp.refresh_now = 1'b1;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LED matrix pixel mapper.
//
// Requests go in on the request channel, results are taken off the result
// channel, with random gaps and stalls where enabled. Each accepted request is
// mapped by an in-bench model of the strip layout, colour path and batch
// counter. Each result beat is checked field by field against the oldest
// expected beat. Named tests cover reset values, every mapping mode and size
// extreme, batch counter saturation, a long output stall and a random mix
// over many settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned NEST_LIMIT = 255;
    localparam logic [lmpm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int LONG_HOLD = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT = 1000;
    localparam int MAX_REPORTS = 10;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [lmpm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lmpm_pkg::SIDE_W-1:0]    cfg_wdata;

    lmpm_req_if req_bus ();
    lmpm_rsp_if rsp_bus ();

    led_matrix_pixel_mapper #(.MAX_NESTING(NEST_LIMIT)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    lmpm_pkg::cfg_t shadow_cfg;
    int             batch_depth;
    lmpm_pkg::rsp_t strip_beats_due[$];
    int             fault_count;
    int             report_count;
    bit             src_idles;
    bit             sink_stalls;
    bit             long_hold_pending;

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit map_request(input lmpm_pkg::req_t rq,
                                       output lmpm_pkg::rsp_t res);
        int x;
        int y;
        int w;
        int h;
        int t;
        int col;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [31:0] idx;
        res = '0;
        if (rq.func == lmpm_pkg::FUNC_BATCH_BEGIN)
        begin
            if (batch_depth < NEST_LIMIT)
                batch_depth++;
            return 1'b0;
        end
        if (rq.func == lmpm_pkg::FUNC_BATCH_END)
        begin
            if (batch_depth > 0)
                batch_depth--;
            if (batch_depth != 0)
                return 1'b0;
            res.refresh_now = 1'b1;
            return 1'b1;
        end
        if (rq.func == lmpm_pkg::FUNC_PIXEL_565)
        begin
            r = {3'b000, rq.packed_colour[15:11]};
            g = {2'b00, rq.packed_colour[10:5]};
            b = {3'b000, rq.packed_colour[4:0]};
        end
        else
        begin
            r = rq.red_in;
            g = rq.green_in;
            b = rq.blue_in;
        end
        x = $signed(rq.pos_x);
        y = $signed(rq.pos_y);
        w = shadow_cfg.matrix_width;
        h = shadow_cfg.matrix_height;
        if (shadow_cfg.flip_x)
            x = (shadow_cfg.swap_axes ? h : w) - x - 1;
        if (shadow_cfg.flip_y)
            y = (shadow_cfg.swap_axes ? w : h) - y - 1;
        if (shadow_cfg.swap_axes)
        begin
            t = x;
            x = y;
            y = t;
        end
        if (x < 0 || x >= w || y < 0 || y >= h)
            return 1'b0;
        col = (shadow_cfg.zigzag_wiring && y[0]) ? w - x - 1 : x;
        idx = y * w + col;
        if (shadow_cfg.invert_colour)
        begin
            r = lmpm_pkg::CHANNEL_MAX - r;
            g = lmpm_pkg::CHANNEL_MAX - g;
            b = lmpm_pkg::CHANNEL_MAX - b;
        end
        res.write_pixel = 1'b1;
        res.led_index   = idx[15:0];
        res.green_out   = g;
        res.red_out     = r;
        res.blue_out    = b;
        res.refresh_now = (batch_depth == 0);
        return 1'b1;
    endfunction

    function automatic string beat_text(input lmpm_pkg::rsp_t beat);
        return $sformatf("wp=%0d idx=%0d g=%0d r=%0d b=%0d refresh=%0d",
                         beat.write_pixel, beat.led_index, beat.green_out,
                         beat.red_out, beat.blue_out, beat.refresh_now);
    endfunction

    function automatic lmpm_pkg::req_t random_request(input bit pixels_only);
        lmpm_pkg::req_t rq;
        int             xr;
        int             yr;
        int             pick;
        xr = shadow_cfg.swap_axes ? shadow_cfg.matrix_height : shadow_cfg.matrix_width;
        yr = shadow_cfg.swap_axes ? shadow_cfg.matrix_width : shadow_cfg.matrix_height;
        rq.packed_colour = 16'($urandom);
        rq.red_in        = 8'($urandom);
        rq.green_in      = 8'($urandom);
        rq.blue_in       = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (!pixels_only && pick < 10)
            rq.func = lmpm_pkg::FUNC_BATCH_BEGIN;
        else if (!pixels_only && pick < 20)
            rq.func = lmpm_pkg::FUNC_BATCH_END;
        else
            rq.func = $urandom_range(0, 1) ? lmpm_pkg::FUNC_PIXEL_BYTES
                                           : lmpm_pkg::FUNC_PIXEL_565;
        if ($urandom_range(0, 6) == 0)
        begin
            rq.pos_x = 16'($urandom);
            rq.pos_y = 16'($urandom);
        end
        else
        begin
            rq.pos_x = 16'(int'($urandom_range(0, xr + 1)) - 1);
            rq.pos_y = 16'(int'($urandom_range(0, yr + 1)) - 1);
        end
        return rq;
    endfunction

    function automatic logic [lmpm_pkg::SIDE_W-1:0] random_side();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return lmpm_pkg::MAX_SIDE;
            2: return lmpm_pkg::SIDE_W'($urandom_range(257, 511));
            default: return lmpm_pkg::SIDE_W'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic send_beat(input lmpm_pkg::req_t item);
        int             gap;
        lmpm_pkg::rsp_t res;
        gap = src_idles ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.func          <= item.func;
        req_bus.pos_x         <= item.pos_x;
        req_bus.pos_y         <= item.pos_y;
        req_bus.packed_colour <= item.packed_colour;
        req_bus.red_in        <= item.red_in;
        req_bus.green_in      <= item.green_in;
        req_bus.blue_in       <= item.blue_in;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        if (map_request(item, res))
            strip_beats_due.push_back(res);
    endtask

    task automatic send_pixel(input logic [1:0] func, input int x, input int y,
                              input logic [15:0] colour, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
        lmpm_pkg::req_t rq;
        rq.func          = func;
        rq.pos_x         = 16'(x);
        rq.pos_y         = 16'(y);
        rq.packed_colour = colour;
        rq.red_in        = r;
        rq.green_in      = g;
        rq.blue_in       = b;
        send_beat(rq);
    endtask

    task automatic send_cmd(input logic [1:0] func);
        lmpm_pkg::req_t rq;
        rq = random_request(1'b1);
        rq.func = func;
        send_beat(rq);
    endtask

    task automatic wait_drain();
        int waited;
        req_bus.valid <= 1'b0;
        waited = 0;
        while (strip_beats_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (strip_beats_due.size() != 0)
        begin
            fault_count += strip_beats_due.size();
            if (report_count < MAX_REPORTS)
                $display("missing: %0d expected beats never arrived, oldest %s",
                         strip_beats_due.size(), beat_text(strip_beats_due[0]));
            report_count++;
            strip_beats_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lmpm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lmpm_pkg::SIDE_W-1:0] val);
        logic [lmpm_pkg::SIDE_W-1:0] side_sat;
        side_sat = (val > lmpm_pkg::MAX_SIDE) ? lmpm_pkg::MAX_SIDE : val;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            lmpm_pkg::REG_MATRIX_WIDTH:  shadow_cfg.matrix_width  = side_sat;
            lmpm_pkg::REG_MATRIX_HEIGHT: shadow_cfg.matrix_height = side_sat;
            lmpm_pkg::REG_FLIP_X:        shadow_cfg.flip_x        = val[0];
            lmpm_pkg::REG_FLIP_Y:        shadow_cfg.flip_y        = val[0];
            lmpm_pkg::REG_SWAP_AXES:     shadow_cfg.swap_axes     = val[0];
            lmpm_pkg::REG_ZIGZAG:        shadow_cfg.zigzag_wiring = val[0];
            lmpm_pkg::REG_INVERT:        shadow_cfg.invert_colour = val[0];
            default: ;
        endcase
    endtask

    task automatic set_matrix(input logic [lmpm_pkg::SIDE_W-1:0] w,
                              input logic [lmpm_pkg::SIDE_W-1:0] h,
                              input bit fx, input bit fy, input bit sw, input bit zz,
                              input bit inv);
        wait_drain();
        write_reg(lmpm_pkg::REG_MATRIX_WIDTH, w);
        write_reg(lmpm_pkg::REG_MATRIX_HEIGHT, h);
        write_reg(lmpm_pkg::REG_FLIP_X, {8'($urandom), fx});
        write_reg(lmpm_pkg::REG_FLIP_Y, {8'($urandom), fy});
        write_reg(lmpm_pkg::REG_SWAP_AXES, {8'($urandom), sw});
        write_reg(lmpm_pkg::REG_ZIGZAG, {8'($urandom), zz});
        write_reg(lmpm_pkg::REG_INVERT, {8'($urandom), inv});
        write_reg(REG_UNUSED, lmpm_pkg::SIDE_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic probe_matrix();
        int xr;
        int yr;
        int cx[7];
        int cy[7];
        xr = shadow_cfg.swap_axes ? shadow_cfg.matrix_height : shadow_cfg.matrix_width;
        yr = shadow_cfg.swap_axes ? shadow_cfg.matrix_width : shadow_cfg.matrix_height;
        cx = '{0, xr - 1, 0, xr - 1, xr, 0, -1};
        cy = '{0, 0, yr - 1, yr - 1, 0, yr, -1};
        for (int i = 0; i < 7; i++)
            send_pixel(i[0] ? lmpm_pkg::FUNC_PIXEL_BYTES : lmpm_pkg::FUNC_PIXEL_565,
                       cx[i], cy[i],
                       16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        repeat (4) send_beat(random_request(1'b1));
    endtask

    task automatic test_reset_defaults();
        src_idles   = 1'b1;
        sink_stalls = 1'b1;
        send_pixel(lmpm_pkg::FUNC_PIXEL_565, 0, 0, 16'hFFFF, 8'h00, 8'h00, 8'h00);
        send_pixel(lmpm_pkg::FUNC_PIXEL_565, 15, 15, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(lmpm_pkg::FUNC_PIXEL_565, 15, 0, 16'hF800, 8'h00, 8'h00, 8'h00);
        send_pixel(lmpm_pkg::FUNC_PIXEL_565, 0, 15, 16'h07E0, 8'h00, 8'h00, 8'h00);
        send_pixel(lmpm_pkg::FUNC_PIXEL_565, 7, 9, 16'h001F, 8'h00, 8'h00, 8'h00);
        send_pixel(lmpm_pkg::FUNC_PIXEL_BYTES, 3, 7, 16'h0000, 8'hFF, 8'h00, 8'h80);
        send_pixel(lmpm_pkg::FUNC_PIXEL_BYTES, 16, 0, 16'h1234, 8'h11, 8'h22, 8'h33);
        send_pixel(lmpm_pkg::FUNC_PIXEL_BYTES, 0, 16, 16'h1234, 8'h11, 8'h22, 8'h33);
        send_pixel(lmpm_pkg::FUNC_PIXEL_BYTES, -1, 5, 16'h1234, 8'h11, 8'h22, 8'h33);
        send_pixel(lmpm_pkg::FUNC_PIXEL_BYTES, 5, -1, 16'h1234, 8'h11, 8'h22, 8'h33);
        send_pixel(lmpm_pkg::FUNC_PIXEL_565, -32768, -32768, 16'hFFFF,
                   8'hFF, 8'hFF, 8'hFF);
        send_pixel(lmpm_pkg::FUNC_PIXEL_565, 32767, 32767, 16'hFFFF,
                   8'hFF, 8'hFF, 8'hFF);
        send_cmd(lmpm_pkg::FUNC_BATCH_BEGIN);
        send_pixel(lmpm_pkg::FUNC_PIXEL_BYTES, 1, 1, 16'h0000, 8'h01, 8'h02, 8'h03);
        send_cmd(lmpm_pkg::FUNC_BATCH_BEGIN);
        send_cmd(lmpm_pkg::FUNC_BATCH_END);
        send_pixel(lmpm_pkg::FUNC_PIXEL_565, 2, 2, 16'hA5A5, 8'h00, 8'h00, 8'h00);
        send_cmd(lmpm_pkg::FUNC_BATCH_END);
        send_cmd(lmpm_pkg::FUNC_BATCH_END);
        send_cmd(lmpm_pkg::FUNC_BATCH_END);
        send_pixel(lmpm_pkg::FUNC_PIXEL_BYTES, 14, 3, 16'h0000, 8'hFE, 8'h7F, 8'h01);
    endtask

    task automatic test_mapping_modes();
        src_idles   = 1'b1;
        sink_stalls = 1'b1;
        set_matrix(9'd5, 9'd3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        probe_matrix();
        set_matrix(9'd5, 9'd3, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        probe_matrix();
        set_matrix(9'd5, 9'd3, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        probe_matrix();
        set_matrix(9'd5, 9'd3, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        probe_matrix();
        set_matrix(9'd4, 9'd6, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        probe_matrix();
        set_matrix(9'd0, 9'd16, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        probe_matrix();
        set_matrix(9'd16, 9'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        probe_matrix();
        set_matrix(9'd511, 9'd300, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
        probe_matrix();
        set_matrix(9'd256, 9'd256, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        probe_matrix();
        set_matrix(9'd1, 9'd1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
        probe_matrix();
    endtask

    task automatic test_batch_saturation();
        src_idles   = 1'b1;
        sink_stalls = 1'b1;
        set_matrix(lmpm_pkg::RESET_WIDTH, lmpm_pkg::RESET_HEIGHT,
                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        repeat (NEST_LIMIT + 1) send_cmd(lmpm_pkg::FUNC_BATCH_BEGIN);
        send_pixel(lmpm_pkg::FUNC_PIXEL_BYTES, 2, 3, 16'h0000, 8'h40, 8'h50, 8'h60);
        repeat (NEST_LIMIT + 1) send_cmd(lmpm_pkg::FUNC_BATCH_END);
        send_pixel(lmpm_pkg::FUNC_PIXEL_565, 3, 2, 16'h5A5A, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_output_stall();
        set_matrix(lmpm_pkg::RESET_WIDTH, lmpm_pkg::RESET_HEIGHT,
                   1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
        src_idles         = 1'b0;
        sink_stalls       = 1'b0;
        long_hold_pending = 1'b1;
        repeat (60) send_beat(random_request(1'b0));
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 10; phase++)
        begin
            set_matrix(random_side(), random_side(), 1'($urandom), 1'($urandom),
                       1'($urandom), 1'($urandom), 1'($urandom));
            src_idles   = phase[0];
            sink_stalls = phase[1];
            repeat (10) send_beat(random_request(1'b0));
        end
    endtask

    initial
    begin : strip_sink
        int             gap;
        lmpm_pkg::rsp_t got;
        lmpm_pkg::rsp_t want;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = sink_stalls ? $urandom_range(0, 9) : 0;
            if (long_hold_pending)
            begin
                gap += LONG_HOLD;
                long_hold_pending = 1'b0;
            end
            if (gap > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_bus.valid !== 1'b1);
            got.write_pixel = rsp_bus.write_pixel;
            got.led_index   = rsp_bus.led_index;
            got.green_out   = rsp_bus.green_out;
            got.red_out     = rsp_bus.red_out;
            got.blue_out    = rsp_bus.blue_out;
            got.refresh_now = rsp_bus.refresh_now;
            if (strip_beats_due.size() == 0)
            begin
                fault_count++;
                if (report_count < MAX_REPORTS)
                    $display("unexpected beat: got %s", beat_text(got));
                report_count++;
            end
            else
            begin
                want = strip_beats_due.pop_front();
                if (got.write_pixel !== want.write_pixel || got.led_index !== want.led_index
                    || got.green_out !== want.green_out || got.red_out !== want.red_out
                    || got.blue_out !== want.blue_out || got.refresh_now !== want.refresh_now)
                begin
                    fault_count++;
                    if (report_count < MAX_REPORTS)
                        $display("mismatch: expected %s, got %s", beat_text(want),
                                 beat_text(got));
                    report_count++;
                end
            end
        end
    end

    initial
    begin
        shadow_cfg = '{matrix_width: lmpm_pkg::RESET_WIDTH,
                       matrix_height: lmpm_pkg::RESET_HEIGHT,
                       flip_x: 1'b0, flip_y: 1'b0, swap_axes: 1'b0,
                       zigzag_wiring: 1'b0, invert_colour: 1'b0};
        batch_depth       = 0;
        fault_count       = 0;
        report_count      = 0;
        src_idles         = 1'b0;
        sink_stalls       = 1'b0;
        long_hold_pending = 1'b0;
        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_index             <= '0;
        cfg_wdata             <= '0;
        req_bus.valid         <= 1'b0;
        req_bus.func          <= lmpm_pkg::FUNC_PIXEL_565;
        req_bus.pos_x         <= '0;
        req_bus.pos_y         <= '0;
        req_bus.packed_colour <= '0;
        req_bus.red_in        <= '0;
        req_bus.green_in      <= '0;
        req_bus.blue_in       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_mapping_modes();
        test_batch_saturation();
        test_output_stall();
        test_random_mix();
        wait_drain();
        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/lmpm_pkg.sv
rtl/core/lmpm_req_if.sv
rtl/core/lmpm_rsp_if.sv
rtl/core/lmpm_cfg.sv
rtl/core/lmpm_map.sv
rtl/core/led_matrix_pixel_mapper.sv
tb/sv/tb.sv
